// File: hw/rtl/rgbc3_pkg.sv
// Package for the RGB 3x3 window convolver: word types, register indexes
// and the fixed field widths. No dependencies.
`default_nettype none

package rgbc3_pkg;

	// Field widths fixed by the port words
	localparam int PIXEL_FIELD_BITS = 8;
	localparam int SUM_BITS         = 20;
	localparam int POS_BITS         = 10;
	localparam int DIM_BITS         = 11;
	localparam int KROW_BITS        = 48;
	localparam int COEFF_BITS       = 16;
	localparam int CFG_INDEX_BITS   = 3;

	// Image size limits
	localparam int MIN_DIM      = 3;
	localparam int HEIGHT_LIMIT = 1024;

	// Saturation bounds of a sum
	localparam int SUM_MAX = 524287;
	localparam int SUM_MIN = -524288;

	// Reset kernel: every coefficient 1.0 in Q8.8
	localparam logic [KROW_BITS-1:0] KROW_RESET = 48'h0100_0100_0100;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_IMAGE_WIDTH  = 3'd0,
		CFG_IMAGE_HEIGHT = 3'd1,
		CFG_KERNEL_ROW0  = 3'd2,
		CFG_KERNEL_ROW1  = 3'd3,
		CFG_KERNEL_ROW2  = 3'd4
	} cfg_reg_t;

	// Input word: one RGB pixel
	typedef struct packed {
		logic [PIXEL_FIELD_BITS-1:0] pixel_red;
		logic [PIXEL_FIELD_BITS-1:0] pixel_green;
		logic [PIXEL_FIELD_BITS-1:0] pixel_blue;
	} pixel_t;

	// Output word: one filtered window
	typedef struct packed {
		logic signed [SUM_BITS-1:0] sum_red;
		logic signed [SUM_BITS-1:0] sum_green;
		logic signed [SUM_BITS-1:0] sum_blue;
		logic [POS_BITS-1:0]        window_x;
		logic [POS_BITS-1:0]        window_y;
		logic                       last_window;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/rgb_conv3x3_window.sv
// A pixel word accepted into stage 1 passes through the stage 2 product and stage 3
// row-sum registers into the stage 4 output register. Throughput: one pixel word
// per cycle unless result_stall holds the output; the line memory does one read
// and one write per cycle, and 27 products feed a two-level registered adder tree.
// Reset clears the pipeline valids, the position counters and the window, and
// loads width and height 1024 and an all 1.0 kernel; the line memory is not cleared.
// Depends on rgbc3_pkg.
`default_nettype none

module rgb_conv3x3_window #(
	parameter int MAX_WIDTH       = 1024,
	parameter int PIXEL_BITS      = 8,
	parameter int COEFF_FRAC_BITS = 8
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  wire                                       pixel_valid,
	output logic                                      pixel_stall,
	input  rgbc3_pkg::pixel_t                         pixel,
	output logic                                      result_valid,
	input  wire                                       result_stall,
	output rgbc3_pkg::result_t                        result,
	input  wire                                       cfg_write,
	input  wire  [rgbc3_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
	input  wire  [rgbc3_pkg::KROW_BITS-1:0]           cfg_data
);
	import rgbc3_pkg::*;

	localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int CMPW  = (WW > DIM_BITS) ? WW : DIM_BITS;
	localparam int RW    = POS_BITS;
	localparam int PB    = PIXEL_BITS;
	localparam int PW    = COEFF_BITS + PB + 1;
	localparam int RSW   = PW + 2;
	localparam int SW    = PW + 4;

	typedef logic [PB-1:0] pix_t;
	typedef pix_t [2:0] rgb_t;

	localparam logic signed [SW-1:0] SAT_HI = SW'(SUM_MAX);
	localparam logic signed [SW-1:0] SAT_LO = SW'(SUM_MIN);

	// Configuration registers
	logic [DIM_BITS-1:0]  image_width_q;
	logic [DIM_BITS-1:0]  image_height_q;
	logic [KROW_BITS-1:0] kernel_q [3];

	// Position counters
	logic [AW-1:0] column_count_q;
	logic [RW-1:0] row_count_q;

	// Pipeline handshake
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;
	logic accept;

	// Stage 1
	rgb_t          pix_s1;
	logic [AW-1:0] col_s1;
	logic          emit_s1;
	logic          last_s1;
	logic [POS_BITS-1:0] x_s1, y_s1;
	logic [2*3*PB-1:0]   rd_s1;

	// Window and line memory
	rgb_t win_q [3][3];
	rgb_t nwin  [3][3];
	rgb_t up1, up2;
	logic [2*3*PB-1:0] line_mem [MAX_WIDTH];

	// Stage 2..4
	logic signed [PW-1:0]  prod_s2 [3][3][3];
	logic signed [RSW-1:0] rsum_s3 [3][3];
	logic                  last_s2, last_s3;
	logic [POS_BITS-1:0]   x_s2, y_s2, x_s3, y_s3;
	result_t               result_s4;

	// Current position decode
	logic [CMPW-1:0] w_ext;
	logic [WW-1:0]   w;
	logic [DIM_BITS-1:0] h;
	logic [AW-1:0]   col_c;
	logic [WW-1:0]   col_next;
	logic            emit_c;
	rgb_t            pix_c;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_BITS'(1024);
			image_height_q <= DIM_BITS'(1024);
			kernel_q[0]    <= KROW_RESET;
			kernel_q[1]    <= KROW_RESET;
			kernel_q[2]    <= KROW_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[DIM_BITS-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[DIM_BITS-1:0];
				CFG_KERNEL_ROW0:  kernel_q[0]    <= cfg_data;
				CFG_KERNEL_ROW1:  kernel_q[1]    <= cfg_data;
				CFG_KERNEL_ROW2:  kernel_q[2]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance each stage when it is empty or the next one moves
	always_comb begin
		adv4        = !v_s4 || !result_stall;
		adv3        = !v_s3 || adv4;
		adv2        = !v_s2 || adv3;
		adv1        = !v_s1 || adv2;
		pixel_stall = !adv1;
		accept      = pixel_valid && adv1;
	end

	// Clamp the image size and decode the incoming pixel position
	always_comb begin
		if (image_width_q < DIM_BITS'(MIN_DIM))
			w_ext = CMPW'(MIN_DIM);
		else if (CMPW'(image_width_q) > CMPW'(MAX_WIDTH))
			w_ext = CMPW'(MAX_WIDTH);
		else
			w_ext = CMPW'(image_width_q);
		w = WW'(w_ext);

		if (image_height_q < DIM_BITS'(MIN_DIM))
			h = DIM_BITS'(MIN_DIM);
		else if (image_height_q > DIM_BITS'(HEIGHT_LIMIT))
			h = DIM_BITS'(HEIGHT_LIMIT);
		else
			h = image_height_q;

		if (WW'(column_count_q) >= w)
			col_c = AW'(w - WW'(1));
		else
			col_c = column_count_q;
		col_next = WW'(column_count_q) + WW'(1);

		emit_c = (WW'(column_count_q) < w) && (DIM_BITS'(row_count_q) < h)
			&& (col_c >= AW'(2)) && (row_count_q >= RW'(2));

		pix_c[0] = PB'(pixel.pixel_red);
		pix_c[1] = PB'(pixel.pixel_green);
		pix_c[2] = PB'(pixel.pixel_blue);
	end

	// Advance the position counters on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (accept) begin
			if (col_next >= w) begin
				column_count_q <= '0;
				if (DIM_BITS'(row_count_q) + DIM_BITS'(1) >= h)
					row_count_q <= '0;
				else
					row_count_q <= row_count_q + RW'(1);
			end else begin
				column_count_q <= AW'(col_next);
				if (DIM_BITS'(row_count_q) >= h)
					row_count_q <= '0;
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv1)
			v_s1 <= pixel_valid;
	end

	// Stage 1 payload and line memory read
	always_ff @(posedge clk) begin
		if (adv1) begin
			pix_s1  <= pix_c;
			col_s1  <= col_c;
			emit_s1 <= emit_c;
			last_s1 <= (WW'(col_c) == w - WW'(1)) && (DIM_BITS'(row_count_q) == h - DIM_BITS'(1));
			x_s1    <= POS_BITS'(col_c - AW'(2));
			y_s1    <= row_count_q - RW'(2);
			rd_s1   <= line_mem[col_c];
		end
	end

	// Rotate the column through the line memory: the older row gets the newer one
	assign up2 = rd_s1[2*3*PB-1:3*PB];
	assign up1 = rd_s1[3*PB-1:0];

	always_ff @(posedge clk) begin
		if (v_s1 && adv2)
			line_mem[col_s1] <= {up1, pix_s1};
	end

	// Shift the window left and bring in the new column
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			nwin[r][0] = win_q[r][1];
			nwin[r][1] = win_q[r][2];
		end
		nwin[0][2] = up2;
		nwin[1][2] = up1;
		nwin[2][2] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					win_q[r][c] <= '0;
		end else if (v_s1 && adv2) begin
			win_q <= nwin;
		end
	end

	// Stage 2: one product per coefficient and channel
	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int k = 0; k < 3; k++)
				for (int r = 0; r < 3; r++)
					for (int c = 0; c < 3; c++)
						prod_s2[k][r][c] <= $signed(kernel_q[r][COEFF_BITS*c +: COEFF_BITS])
							* $signed({1'b0, nwin[r][c][k]});
			last_s2 <= last_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
		end
	end

	// Stage 3: sum each kernel row
	always_ff @(posedge clk) begin
		if (adv3) begin
			for (int k = 0; k < 3; k++)
				for (int r = 0; r < 3; r++)
					rsum_s3[k][r] <= RSW'(prod_s2[k][r][0]) + RSW'(prod_s2[k][r][1])
						+ RSW'(prod_s2[k][r][2]);
			last_s3 <= last_s2;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
		end
	end

	// Stage 4: total, drop fraction bits, saturate
	logic signed [SW-1:0]       total   [3];
	logic signed [SW-1:0]       shifted [3];
	logic signed [SUM_BITS-1:0] sat     [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			total[k]   = SW'(rsum_s3[k][0]) + SW'(rsum_s3[k][1]) + SW'(rsum_s3[k][2]);
			shifted[k] = total[k] >>> COEFF_FRAC_BITS;
			if (shifted[k] > SAT_HI)
				sat[k] = SUM_BITS'(SAT_HI);
			else if (shifted[k] < SAT_LO)
				sat[k] = SUM_BITS'(SAT_LO);
			else
				sat[k] = SUM_BITS'(shifted[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			result_s4.sum_red     <= sat[0];
			result_s4.sum_green   <= sat[1];
			result_s4.sum_blue    <= sat[2];
			result_s4.window_x    <= x_s3;
			result_s4.window_y    <= y_s3;
			result_s4.last_window <= last_s3;
		end
	end

	// Valids of stages 2..4; words without a result drop out after stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv2)
				v_s2 <= v_s1 && emit_s1;
			if (adv3)
				v_s3 <= v_s2;
			if (adv4)
				v_s4 <= v_s3;
		end
	end

	assign result_valid = v_s4;
	assign result       = result_s4;

	// An empty output register never holds back the input
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !pixel_stall)
		else $error("input stalled with an empty output register");

	// A result only appears from stage 3 or is the one already held
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s4) |-> $past(v_s3))
		else $error("result valid without a word in stage 3");

	// Stage 2 only fills from a window-completing word in stage 1
	a_stage2_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s2) |-> $past(v_s1 && emit_s1))
		else $error("stage 2 filled without a completed window");

endmodule

`default_nettype wire
